// File: hw/rtl/mrkl_pkg.sv
// Shared types, constants and helpers for the SHA-1 Merkle root builder.
// Used by merkle_root_sha1_builder_top and its testbench; depends on nothing else.
package mrkl_pkg;

    // Stack capacity and the derived widths.
    localparam int MAX_LEVELS = 20;
    localparam int DEPTH_W    = $clog2(MAX_LEVELS + 1);
    localparam int IDX_W      = $clog2(MAX_LEVELS);
    localparam int HGT_W      = 5;
    localparam int LEAF_W     = 20;
    localparam logic [LEAF_W-1:0] LEAF_MAX = {LEAF_W{1'b1}};

    // Rounds per compression; the counter also marks the finishing add.
    localparam int ROUNDS = 80;
    localparam int RND_W  = 7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXP_HIGH   = 2'd0;
    localparam logic [1:0] CFG_EXP_MIDDLE = 2'd1;
    localparam logic [1:0] CFG_EXP_LOW    = 2'd2;

    typedef logic [0:4][31:0]  dig_t;
    typedef logic [0:15][31:0] blk_t;

    localparam dig_t SHA_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                               32'h10325476, 32'hC3D2E1F0};

    // Message length words of the padding blocks, in bits.
    localparam logic [31:0] LEN_LEAF = 32'd512;
    localparam logic [31:0] LEN_PAIR = 32'd320;
    localparam logic [31:0] PAD_MARK = 32'h80000000;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        file_end;
    } item_t;

    typedef struct packed {
        logic [31:0]       root_high;
        logic [63:0]       root_middle;
        logic [63:0]       root_low;
        logic [LEAF_W-1:0] leaf_total;
        logic              root_matches;
        logic              file_empty;
        logic              too_many_leaves;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEAF,
        ST_LEAF_C1,
        ST_LEAF_C2,
        ST_MERGE_CHK,
        ST_MERGE_C,
        ST_TAIL,
        ST_FOLD_CHK,
        ST_FOLD_C,
        ST_EMIT
    } state_t;

    // Round constant for a round number.
    function automatic logic [31:0] round_k(input logic [RND_W-1:0] rnd);
        logic [31:0] k;
        if (rnd < RND_W'(20))
            k = 32'h5A827999;
        else if (rnd < RND_W'(40))
            k = 32'h6ED9EBA1;
        else if (rnd < RND_W'(60))
            k = 32'h8F1BBCDC;
        else
            k = 32'hCA62C1D6;
        return k;
    endfunction

    // Round function for a round number.
    function automatic logic [31:0] round_f(input logic [RND_W-1:0] rnd,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (rnd < RND_W'(20))
            f = (b & c) | (~b & d);
        else if (rnd < RND_W'(40))
            f = b ^ c ^ d;
        else if (rnd < RND_W'(60))
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

// File: hw/rtl/merkle_root_sha1_builder_top.sv
// SHA-1 Merkle root builder: word intake, leaf hashing, subtree stack and fold.
// Depends on mrkl_pkg for types, constants and the SHA-1 round helpers.
//
// Usage. File words arrive on the item channel (item_valid / item_stall),
// eight bytes a beat, first byte in the top bits. Every eighth stored word
// closes a 64-byte block, which is hashed into a leaf and merged into a
// stack of subtree digests. The beat flagged file_end closes the file: a
// short last block is zero-filled and hashed, the stack is folded and one
// beat leaves on the result channel (result_valid / result_stall).
// A word that does not close a block leaves the sequencer idle and ready for
// the next word. A leaf takes two SHA-1 compressions plus one per merge, and
// the fold one per stack entry below the top; each compression runs its
// rounds and the chaining add on the single shared round unit. item_stall
// is high while the sequencer is busy. The result sits in an output
// register, so a stalled result does not hold up the next file until its
// own result is ready.
// Reset clears the per-file state and the expected root; the stack
// entries themselves are not cleared, as only entries below the stack
// depth are read.
module merkle_root_sha1_builder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  mrkl_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output mrkl_pkg::result_t   result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import mrkl_pkg::*;

    state_t                 state_reg, state_next;
    logic [63:0]            buf_reg [8];
    logic [63:0]            buf_next [8];
    logic [2:0]             pos_reg, pos_next;
    logic                   fe_reg, fe_next;
    logic [LEAF_W-1:0]      cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [HGT_W-1:0]       hgt_reg, hgt_next;
    dig_t                   carry_reg, carry_next;
    dig_t                   stk_hash_reg [MAX_LEVELS];
    logic [HGT_W-1:0]       stk_hgt_reg [MAX_LEVELS];
    logic                   push;
    dig_t                   wrk_reg, wrk_next;
    dig_t                   hv_reg, hv_next;
    blk_t                   win_reg, win_next;
    logic [RND_W-1:0]       rnd_reg, rnd_next;
    logic [31:0]            exp_high_reg;
    logic [63:0]            exp_mid_reg, exp_low_reg;
    result_t                res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;

    // Helper values for the datapath.
    logic [3:0]             vbc;
    logic [63:0]            masked;
    logic [IDX_W-1:0]       top_idx, push_idx;
    dig_t                   top_hash, fin;
    blk_t                   leaf_blk, pad_blk, pair_blk;
    logic [31:0]            t_sum, w_new;
    logic                   in_rounds, empty;
    dig_t                   root;

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Byte masking of the incoming word.
    always_comb
    begin
        vbc = (item.valid_bytes > 4'd8) ? 4'd8 : item.valid_bytes;
        if (vbc == 4'd8)
            masked = item.data_word;
        else
            masked = item.data_word & ~(64'hFFFF_FFFF_FFFF_FFFF >> {vbc, 3'b000});
    end

    // Stack top and message blocks.
    assign top_idx  = IDX_W'(depth_reg - DEPTH_W'(1));
    assign push_idx = depth_reg[IDX_W-1:0];
    assign top_hash = stk_hash_reg[top_idx];

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            leaf_blk[2*j]   = buf_reg[j][63:32];
            leaf_blk[2*j+1] = buf_reg[j][31:0];
        end
        pad_blk     = '0;
        pad_blk[0]  = PAD_MARK;
        pad_blk[15] = LEN_LEAF;
        pair_blk    = '0;
        for (int i = 0; i < 5; i++)
        begin
            pair_blk[i]   = top_hash[i];
            pair_blk[i+5] = carry_reg[i];
        end
        pair_blk[10] = PAD_MARK;
        pair_blk[15] = LEN_PAIR;
    end

    // Shared SHA-1 round unit and the chaining add.
    always_comb
    begin
        t_sum = {wrk_reg[0][26:0], wrk_reg[0][31:27]}
              + round_f(rnd_reg, wrk_reg[1], wrk_reg[2], wrk_reg[3])
              + wrk_reg[4] + round_k(rnd_reg) + win_reg[0];
        w_new = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_new = {w_new[30:0], w_new[31]};
        for (int i = 0; i < 5; i++)
            fin[i] = hv_reg[i] + wrk_reg[i];
    end

    assign in_rounds = (rnd_reg != RND_W'(ROUNDS));
    assign empty     = (cnt_reg == '0) && !ovf_reg;
    assign root      = (empty || ovf_reg) ? '0 : carry_reg;

    // Sequencer: next state and next register values.
    always_comb
    begin
        state_next     = state_reg;
        buf_next       = buf_reg;
        pos_next       = pos_reg;
        fe_next        = fe_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        depth_next     = depth_reg;
        hgt_next       = hgt_reg;
        carry_next     = carry_reg;
        push           = 1'b0;
        wrk_next       = wrk_reg;
        hv_next        = hv_reg;
        win_next       = win_reg;
        rnd_next       = rnd_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && result_stall;

        // A round runs in every compression state until the count is spent.
        if ((state_reg == ST_LEAF_C1 || state_reg == ST_LEAF_C2 ||
             state_reg == ST_MERGE_C || state_reg == ST_FOLD_C) && in_rounds)
        begin
            wrk_next = {t_sum, wrk_reg[0],
                        {wrk_reg[1][1:0], wrk_reg[1][31:2]},
                        wrk_reg[2], wrk_reg[3]};
            win_next = {win_reg[1:15], w_new};
            rnd_next = rnd_reg + RND_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    fe_next = item.file_end;
                    if (vbc != 4'd0)
                    begin
                        buf_next[pos_reg] = masked;
                        pos_next          = pos_reg + 3'd1;
                    end
                    if (vbc != 4'd0 && pos_reg == 3'd7)
                        state_next = ST_LEAF;
                    else if (item.file_end)
                        state_next = ST_TAIL;
                end
            end
            ST_LEAF:
            begin
                if (ovf_reg)
                    state_next = fe_reg ? ST_TAIL : ST_IDLE;
                else if (cnt_reg == LEAF_MAX)
                begin
                    ovf_next   = 1'b1;
                    state_next = fe_reg ? ST_TAIL : ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + LEAF_W'(1);
                    hv_next    = SHA_IV;
                    wrk_next   = SHA_IV;
                    win_next   = leaf_blk;
                    rnd_next   = '0;
                    state_next = ST_LEAF_C1;
                end
            end
            ST_LEAF_C1:
            begin
                if (!in_rounds)
                begin
                    hv_next    = fin;
                    wrk_next   = fin;
                    win_next   = pad_blk;
                    rnd_next   = '0;
                    state_next = ST_LEAF_C2;
                end
            end
            ST_LEAF_C2:
            begin
                if (!in_rounds)
                begin
                    carry_next = fin;
                    hgt_next   = '0;
                    state_next = ST_MERGE_CHK;
                end
            end
            ST_MERGE_CHK:
            begin
                if (depth_reg != '0 && stk_hgt_reg[top_idx] == hgt_reg)
                begin
                    hv_next    = SHA_IV;
                    wrk_next   = SHA_IV;
                    win_next   = pair_blk;
                    rnd_next   = '0;
                    state_next = ST_MERGE_C;
                end
                else if (depth_reg >= DEPTH_W'(MAX_LEVELS))
                begin
                    ovf_next   = 1'b1;
                    state_next = fe_reg ? ST_TAIL : ST_IDLE;
                end
                else
                begin
                    push       = 1'b1;
                    depth_next = depth_reg + DEPTH_W'(1);
                    state_next = fe_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_MERGE_C:
            begin
                if (!in_rounds)
                begin
                    carry_next = fin;
                    depth_next = depth_reg - DEPTH_W'(1);
                    hgt_next   = hgt_reg + HGT_W'(1);
                    state_next = ST_MERGE_CHK;
                end
            end
            ST_TAIL:
            begin
                // Zero-fill a partly filled last block, else start the fold, or emit on an empty stack or overflow.
                if (pos_reg != 3'd0)
                begin
                    for (int j = 0; j < 8; j++)
                        if (3'(j) >= pos_reg)
                            buf_next[j] = '0;
                    pos_next   = 3'd0;
                    state_next = ST_LEAF;
                end
                else if (ovf_reg || depth_reg == '0)
                    state_next = ST_EMIT;
                else
                begin
                    carry_next = top_hash;
                    depth_next = depth_reg - DEPTH_W'(1);
                    state_next = ST_FOLD_CHK;
                end
            end
            ST_FOLD_CHK:
            begin
                if (depth_reg == '0)
                    state_next = ST_EMIT;
                else
                begin
                    hv_next    = SHA_IV;
                    wrk_next   = SHA_IV;
                    win_next   = pair_blk;
                    rnd_next   = '0;
                    state_next = ST_FOLD_C;
                end
            end
            ST_FOLD_C:
            begin
                if (!in_rounds)
                begin
                    carry_next = fin;
                    depth_next = depth_reg - DEPTH_W'(1);
                    state_next = ST_FOLD_CHK;
                end
            end
            ST_EMIT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_next.root_high       = root[0];
                    res_next.root_middle     = {root[1], root[2]};
                    res_next.root_low        = {root[3], root[4]};
                    res_next.leaf_total      = cnt_reg;
                    res_next.root_matches    = !empty && !ovf_reg &&
                                               root[0] == exp_high_reg &&
                                               {root[1], root[2]} == exp_mid_reg &&
                                               {root[3], root[4]} == exp_low_reg;
                    res_next.file_empty      = empty;
                    res_next.too_many_leaves = ovf_reg;
                    res_valid_next           = 1'b1;
                    for (int j = 0; j < 8; j++)
                        buf_next[j] = '0;
                    pos_next   = 3'd0;
                    fe_next    = 1'b0;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    depth_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Per-file control state and the result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 8; j++)
                buf_reg[j] <= '0;
            pos_reg       <= '0;
            fe_reg        <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            depth_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            pos_reg       <= pos_next;
            fe_reg        <= fe_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            depth_reg     <= depth_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Expected root registers, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_high_reg <= '0;
            exp_mid_reg  <= '0;
            exp_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXP_HIGH:   exp_high_reg <= cfg_data[31:0];
                CFG_EXP_MIDDLE: exp_mid_reg  <= cfg_data;
                CFG_EXP_LOW:    exp_low_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Hash datapath and result payload; no reset needed.
    always_ff @(posedge clk)
    begin
        hgt_reg   <= hgt_next;
        carry_reg <= carry_next;
        wrk_reg   <= wrk_next;
        hv_reg    <= hv_next;
        win_reg   <= win_next;
        rnd_reg   <= rnd_next;
        res_reg   <= res_next;
    end

    // Subtree stack, written only on a push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_hash_reg[push_idx] <= carry_reg;
            stk_hgt_reg[push_idx]  <= hgt_reg;
        end
    end

endmodule

// File: tb/sv/tb_merkle_root_sha1_builder_top.sv
// Self-checking testbench for merkle_root_sha1_builder_top: drives files as word beats,
// predicts each root with its own SHA-1 and subtree stack, and checks every result beat.
// Depends on mrkl_pkg and merkle_root_sha1_builder_top.
module tb_merkle_root_sha1_builder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrkl_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    merkle_root_sha1_builder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Word beats waiting to be sent, and roots still owed by the block.
    item_t   word_backlog[$];
    result_t root_backlog[$];
    item_t   last_file[$];
    item_t   this_file[$];

    // Predictor copy of the configuration and the per-file state.
    logic [159:0] want_root;
    logic [63:0]  file_buf[8];
    int unsigned  word_pos;
    logic [159:0] sub_hash[MAX_LEVELS];
    int unsigned  sub_height[MAX_LEVELS];
    int unsigned  sub_depth;
    int unsigned  leaves;
    bit           overflowed;
    logic [159:0] last_root;

    int  mismatches;
    int  files_seen;
    int  matches_seen;
    int  words_sent;
    bit  quiet;

    // One SHA-1 compression of a 512-bit block into a chaining value.
    function automatic logic [159:0] sha_round_block(input logic [159:0] hv,
                                                     input logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++)
        begin
            t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
            w[i] = {t[30:0], t[31]};
        end
        {a, b, c, d, e} = hv;
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d,
                hv[31:0] + e};
    endfunction

    // Digest of one full 64-byte block: the data, then a pure padding block.
    function automatic logic [159:0] leaf_digest(input logic [511:0] data);
        logic [159:0] hv;
        hv = sha_round_block(SHA_IV, data);
        return sha_round_block(hv, {32'h80000000, 416'b0, 64'd512});
    endfunction

    // Digest of the 40-byte left||right pair; fits one padded block.
    function automatic logic [159:0] pair_digest(input logic [159:0] l,
                                                 input logic [159:0] r);
        return sha_round_block(SHA_IV, {l, r, 32'h80000000, 96'b0, 64'd320});
    endfunction

    task automatic clear_file_state();
        foreach (file_buf[i])
            file_buf[i] = '0;
        word_pos   = 0;
        sub_depth  = 0;
        leaves     = 0;
        overflowed = 0;
    endtask

    // Hash the buffered block and merge it into the subtree stack.
    task automatic absorb_block();
        logic [159:0] carry;
        int unsigned  h;
        carry = leaf_digest({file_buf[0], file_buf[1], file_buf[2], file_buf[3],
                             file_buf[4], file_buf[5], file_buf[6], file_buf[7]});
        h = 0;
        if (overflowed)
            return;
        if (leaves >= int'(LEAF_MAX))
        begin
            overflowed = 1;
            return;
        end
        leaves++;
        while (sub_depth > 0 && sub_height[sub_depth - 1] == h)
        begin
            carry = pair_digest(sub_hash[sub_depth - 1], carry);
            sub_depth--;
            h++;
        end
        if (sub_depth >= MAX_LEVELS)
        begin
            overflowed = 1;
            return;
        end
        sub_hash[sub_depth]   = carry;
        sub_height[sub_depth] = h & 31;
        sub_depth++;
    endtask

    // Advance the predictor by one accepted word; owe a root on file end.
    task automatic absorb_word(input item_t it);
        int unsigned  vb;
        logic [63:0]  word;
        logic [159:0] root;
        result_t      r;
        vb   = (it.valid_bytes > 8) ? 8 : it.valid_bytes;
        word = it.data_word;
        if (vb > 0)
        begin
            if (vb < 8)
                word &= ~({64{1'b1}} >> (8 * vb));
            file_buf[word_pos] = word;
            word_pos = (word_pos + 1) % 8;
            if (word_pos == 0)
                absorb_block();
        end
        if (!it.file_end)
            return;
        if (word_pos != 0)
        begin
            for (int i = word_pos; i < 8; i++)
                file_buf[i] = '0;
            word_pos = 0;
            absorb_block();
        end
        r = '0;
        r.file_empty      = (leaves == 0) && !overflowed;
        r.too_many_leaves = overflowed;
        r.leaf_total      = leaves[LEAF_W-1:0];
        if (!r.file_empty && !overflowed && sub_depth > 0)
        begin
            root = sub_hash[sub_depth - 1];
            for (int i = sub_depth - 1; i > 0; i--)
                root = pair_digest(sub_hash[i - 1], root);
            {r.root_high, r.root_middle, r.root_low} = root;
            r.root_matches = (root == want_root);
            last_root = root;
        end
        root_backlog.push_back(r);
        clear_file_state();
    endtask

    // Clock and reset.
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
    end

    // Driver: presents queued beats, holds them while stalled, idles at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                absorb_word(item);
                words_sent++;
            end
            if (!item_valid || !item_stall)
            begin
                if (word_backlog.size() > 0 && (quiet || $urandom_range(99) >= 6))
                begin
                    item_valid <= 1;
                    item       <= word_backlog.pop_front();
                end
                else
                    item_valid <= 0;
            end
        end
    end

    task automatic check_field(input string name, input logic [159:0] want,
                               input logic [159:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Monitor: stalls at random and checks each accepted result beat.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            result_stall <= 0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                files_seen++;
                if (root_backlog.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat with nothing expected: %h", result);
                end
                else
                begin
                    want = root_backlog.pop_front();
                    matches_seen += want.root_matches;
                    check_field("root_high", want.root_high, result.root_high);
                    check_field("root_middle", want.root_middle, result.root_middle);
                    check_field("root_low", want.root_low, result.root_low);
                    check_field("leaf_total", want.leaf_total, result.leaf_total);
                    check_field("root_matches", want.root_matches, result.root_matches);
                    check_field("file_empty", want.file_empty, result.file_empty);
                    check_field("too_many_leaves", want.too_many_leaves,
                                result.too_many_leaves);
                end
            end
            result_stall <= !quiet && ($urandom_range(99) < 6);
        end
    end

    // Queue one word beat of the file being assembled.
    task automatic add_word(input logic [63:0] data, input int unsigned vb, input bit fe);
        item_t it;
        it.data_word   = data;
        it.valid_bytes = vb[3:0];
        it.file_end    = fe;
        this_file.push_back(it);
    endtask

    // Hand the assembled file to the driver and remember it for a replay.
    task automatic send_file();
        last_file = this_file;
        foreach (this_file[i])
            word_backlog.push_back(this_file[i]);
        this_file.delete();
    endtask

    task automatic random_file(input int unsigned nwords);
        for (int i = 0; i < nwords; i++)
        begin
            if (i == nwords - 1)
                add_word({$urandom, $urandom}, $urandom_range(15), 1);
            else if ($urandom_range(9) == 0)
                add_word({$urandom, $urandom}, $urandom_range(15), 0);
            else
                add_word({$urandom, $urandom}, 8, 0);
        end
        send_file();
    endtask

    task automatic wait_idle();
        while (word_backlog.size() > 0 || root_backlog.size() > 0 || item_valid)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_EXP_HIGH)
            want_root[159:128] = data[31:0];
        else if (idx == CFG_EXP_MIDDLE)
            want_root[127:64] = data;
        else if (idx == CFG_EXP_LOW)
            want_root[63:0] = data;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic set_expected(input logic [159:0] root);
        write_reg(CFG_EXP_HIGH, {32'b0, root[159:128]});
        write_reg(CFG_EXP_MIDDLE, root[127:64]);
        write_reg(CFG_EXP_LOW, root[63:0]);
    endtask

    // Stimulus phases.
    initial
    begin
        cfg_we     = 0;
        cfg_index  = CFG_EXP_HIGH;
        cfg_data   = '0;
        want_root  = '0;
        last_root  = '0;
        mismatches = 0;
        files_seen = 0;
        matches_seen = 0;
        words_sent = 0;
        quiet      = 0;
        clear_file_state();
        @(posedge rst_n);

        // Directed: an empty file, one word, one leaf exactly, two leaves, odd bytes.
        add_word('0, 0, 1);
        send_file();
        add_word({64{1'b1}}, 15, 1);
        send_file();
        add_word({64{1'b1}}, 3, 1);
        send_file();
        for (int i = 0; i < 8; i++)
            add_word({64{1'b1}}, 8, i == 7);
        send_file();
        for (int i = 0; i < 9; i++)
            add_word((i == 2) ? {64{1'b1}} : {$urandom, $urandom}, (i == 2) ? 5 : 8,
                     i == 8);
        send_file();
        add_word('0, 8, 0);
        add_word({64{1'b1}}, 0, 0);
        add_word({$urandom, $urandom}, 1, 1);
        send_file();
        wait_idle();

        // Expected root set to a real root: the replay must match.
        set_expected(last_root);
        foreach (last_file[i])
            word_backlog.push_back(last_file[i]);
        wait_idle();
        write_reg(CFG_EXP_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_EXP_MIDDLE, {64{1'b1}});
        write_reg(CFG_EXP_LOW, {64{1'b1}});

        // Random files in four phases, one with no idling.
        for (int phase = 0; phase < 4; phase++)
        begin
            quiet = (phase == 2);
            while (words_sent + word_backlog.size() < 180 * (phase + 1))
                random_file(($urandom_range(7) == 0) ? $urandom_range(33, 72)
                                                     : $urandom_range(1, 20));
            wait_idle();
            if (phase == 1)
            begin
                set_expected(last_root);
                foreach (last_file[i])
                    word_backlog.push_back(last_file[i]);
                wait_idle();
            end
            set_expected({$urandom, $urandom, $urandom, $urandom, $urandom});
        end
        quiet = 0;
        set_expected('0);
        random_file(12);
        wait_idle();

        $display("Checked %0d roots over %0d words, %0d of them matching the stored root.",
                 files_seen, words_sent, matches_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #8ms;
        $display("Timed out with %0d roots outstanding.", root_backlog.size());
        $display("tb: failure");
        $finish;
    end

endmodule
